>>> sv/dtfp_pkg.sv
// Shared types and constants for the decimal text to fixed point parser.
package dtfp_pkg;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NAN = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // fraction digit position, saturates once the weight has reached zero
    localparam int         WIDX_W   = 4;
    localparam logic [3:0] WIDX_MAX = 4'd9;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_char_req;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } t_result;

    // floor(2^32 / 10^(idx+1)); zero from the tenth digit on
    function automatic logic [31:0] frac_weight(input logic [WIDX_W-1:0] idx);
        logic [31:0] w;
        case (idx)
            4'd0:    w = 32'd429496729;
            4'd1:    w = 32'd42949672;
            4'd2:    w = 32'd4294967;
            4'd3:    w = 32'd429496;
            4'd4:    w = 32'd42949;
            4'd5:    w = 32'd4294;
            4'd6:    w = 32'd429;
            4'd7:    w = 32'd42;
            4'd8:    w = 32'd4;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

>>> sv/dtfp_in_stage.sv
// Input register for character requests.
module dtfp_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dtfp_pkg::t_char_req  i_req,
    input  logic                 i_take,
    output logic                 o_valid,
    output dtfp_pkg::t_char_req  o_req
);

    logic                r_valid;
    dtfp_pkg::t_char_req r_req;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

>>> sv/dtfp_parser.sv
// Parse state registers and per-character step logic.
module dtfp_parser #(
    parameter int FRAC_BITS = 32,
    parameter int INT_BITS  = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dtfp_pkg::t_char_req i_req,
    input  logic                i_out_free,
    output logic                o_take,
    output logic                o_res_valid,
    output dtfp_pkg::t_result   o_res
);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_INT    = 3'd2;
    localparam logic [2:0] PH_FRAC   = 3'd3;
    localparam logic [2:0] PH_BAD    = 3'd4;

    localparam logic [63:0] SAT_MAG = (64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1;

    logic [2:0]                  r_phase, n_phase;
    logic                        r_neg, n_neg;
    logic [INT_BITS-1:0]         r_int, n_int;
    logic [31:0]                 r_frac, n_frac;
    logic [dtfp_pkg::WIDX_W-1:0] r_widx, n_widx;
    logic                        r_ovf, n_ovf;

    logic                is_digit;
    logic [3:0]          dig;
    logic [INT_BITS+3:0] int_next;
    logic                int_over;
    logic [63:0]         mag;
    logic [1:0]          status;

    assign is_digit = (i_req.char_code >= dtfp_pkg::CH_ZERO)
                   && (i_req.char_code <= dtfp_pkg::CH_NINE);
    assign dig      = is_digit ? 4'(i_req.char_code - dtfp_pkg::CH_ZERO) : 4'd0;
    // sum*10 + digit; anything above the INT_BITS field exceeds the bound
    assign int_next = ({4'd0, r_int} << 3) + ({4'd0, r_int} << 1)
                    + (INT_BITS+4)'(dig);
    assign int_over = |int_next[INT_BITS+3:INT_BITS];

    assign o_take = i_valid && (!i_req.last_char || i_out_free);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_int   = r_int;
        n_frac  = r_frac;
        n_widx  = r_widx;
        n_ovf   = r_ovf;
        unique case (r_phase)
            PH_START: begin
                if (i_req.char_code == dtfp_pkg::CH_MINUS
                        || i_req.char_code == dtfp_pkg::CH_PLUS) begin
                    n_neg   = (i_req.char_code == dtfp_pkg::CH_MINUS);
                    n_phase = PH_SIGNED;
                end else if (is_digit) begin
                    n_int   = int_over ? '1 : int_next[INT_BITS-1:0];
                    n_ovf   = r_ovf || int_over;
                    n_phase = PH_INT;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_SIGNED: begin
                if (is_digit) begin
                    n_int   = int_over ? '1 : int_next[INT_BITS-1:0];
                    n_ovf   = r_ovf || int_over;
                    n_phase = PH_INT;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    n_int = int_over ? '1 : int_next[INT_BITS-1:0];
                    n_ovf = r_ovf || int_over;
                end else if (i_req.char_code == dtfp_pkg::CH_POINT) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_FRAC: begin
                if (is_digit) begin
                    n_frac = r_frac + 32'(dig * dtfp_pkg::frac_weight(r_widx));
                    n_widx = (r_widx == dtfp_pkg::WIDX_MAX) ? r_widx : r_widx + 4'd1;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            default: begin
                n_phase = PH_BAD;
            end
        endcase
    end

    always_comb begin
        if (n_phase != PH_INT && n_phase != PH_FRAC) begin
            status = dtfp_pkg::ST_NAN;
            mag    = 64'd0;
        end else if (n_ovf) begin
            status = dtfp_pkg::ST_OVF;
            mag    = SAT_MAG;
        end else begin
            status = dtfp_pkg::ST_OK;
            mag    = (64'(n_int) << FRAC_BITS) | 64'(n_frac >> (32 - FRAC_BITS));
        end
        o_res.status = status;
        o_res.value  = (n_neg && status != dtfp_pkg::ST_NAN) ? (~mag + 64'd1) : mag;
    end

    assign o_res_valid = o_take && i_req.last_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_req.last_char)) begin
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_int   <= '0;
            r_frac  <= 32'd0;
            r_widx  <= '0;
            r_ovf   <= 1'b0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_widx  <= n_widx;
            r_ovf   <= n_ovf;
        end
    end

endmodule

>>> sv/dtfp_out_stage.sv
// Result register on the output channel.
module dtfp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dtfp_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output dtfp_pkg::t_result o_res
);

    logic              r_valid;
    dtfp_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

endmodule

>>> sv/decimal_text_to_fixed_point_top.sv
// Top level of the decimal text to signed fixed point parser.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_ready       | i_char_code[7:0], i_last_char
//  out     | from block| o_out_valid / i_out_ready     | o_value[63:0] (Q), o_status[1:0]
//
// One character request per cycle is accepted, unless a last character waits
// in the input register for the result register to free up. Each request
// goes through an input register, one pass of step logic (x10 shift-add, 4x32
// weight multiply, 32-bit add) and, on the last character, into the result register.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// parse state. A stalled result only holds back a request flagged as last;
// other characters keep flowing while the result waits.
module decimal_text_to_fixed_point_top #(
    parameter int FRAC_BITS = 32,
    parameter int INT_BITS  = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_char,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_value,
    output logic [1:0]         o_status
);

    dtfp_pkg::t_char_req in_req, reg_req;
    dtfp_pkg::t_result   step_res, out_res;
    logic                reg_valid;
    logic                take;
    logic                res_valid;
    logic                out_free;

    assign in_req.char_code = i_char_code;
    assign in_req.last_char = i_last_char;

    dtfp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (in_req),
        .i_take  (take),
        .o_valid (reg_valid),
        .o_req   (reg_req)
    );

    // parse state advances on every taken character; a final one is taken only when its result can be handed on
    dtfp_parser #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (reg_valid),
        .i_req       (reg_req),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (step_res)
    );

    dtfp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (step_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_value  = out_res.value;
    assign o_status = out_res.status;

endmodule

>>> dv/tb_decimal_text_to_fixed_point_top.sv
// Testbench for the decimal text to fixed point parser: directed and random text, scored live.
module tb_decimal_text_to_fixed_point_top;

    localparam int FRAC_BITS  = 32;
    localparam int INT_BITS   = 31;
    localparam int CHAR_GOAL  = 1750;   // directed plus about 1700 random characters
    localparam int IDLE_LIMIT = 500;    // cycles with no handshake on either side

    typedef enum logic [2:0] {
        PS_START,
        PS_SIGNED,
        PS_INT,
        PS_FRAC,
        PS_BAD
    } t_parse_phase;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_char_code = 8'd0;
    logic               i_last_char = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    logic signed [63:0] o_value;
    logic [1:0]         o_status;

    // parse state mirrored on the testbench side
    t_parse_phase pp_phase;
    logic         pp_negative;
    logic [31:0]  pp_int;
    logic [31:0]  pp_frac;
    logic [31:0]  pp_weight;
    logic         pp_ovf;

    dtfp_pkg::t_result expected_results[$];
    int      errors      = 0;
    int      chars_sent  = 0;
    int      idle_cycles = 0;
    int      ready_hold  = 0;
    bit      steady      = 1'b0;   // no gaps or stalls while set

    decimal_text_to_fixed_point_top #(
        .FRAC_BITS(FRAC_BITS),
        .INT_BITS (INT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_char_code(i_char_code),
        .i_last_char(i_last_char),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_value    (o_value),
        .o_status   (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [7:0] pick_digit(input int style);
        if (style == 0) return dtfp_pkg::CH_NINE;
        if (style == 1) return dtfp_pkg::CH_ZERO;
        return dtfp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // ------------------------------------------------------------------
    // Parse predictor
    // ------------------------------------------------------------------
    task automatic clear_parse();
        pp_phase    = PS_START;
        pp_negative = 1'b0;
        pp_int      = 32'd0;
        pp_frac     = 32'd0;
        pp_weight   = 32'((64'd1 << 32) / 10);
        pp_ovf      = 1'b0;
    endtask

    // integer part saturates at 2^INT_BITS - 1
    task automatic push_int_digit(input logic [3:0] d);
        logic [63:0] bound;
        logic [63:0] nxt;
        bound = (64'd1 << INT_BITS) - 64'd1;
        nxt   = 64'(pp_int) * 64'd10 + 64'(d);
        if (nxt > bound) begin
            nxt    = bound;
            pp_ovf = 1'b1;
        end
        pp_int = nxt[31:0];
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last);
        logic              is_digit;
        logic [3:0]        d;
        logic [63:0]       mag;
        dtfp_pkg::t_result res;
        is_digit = (c >= dtfp_pkg::CH_ZERO) && (c <= dtfp_pkg::CH_NINE);
        d        = is_digit ? 4'(c - dtfp_pkg::CH_ZERO) : 4'd0;
        case (pp_phase)
            PS_START: begin
                if (c == dtfp_pkg::CH_MINUS || c == dtfp_pkg::CH_PLUS) begin
                    pp_negative = (c == dtfp_pkg::CH_MINUS);
                    pp_phase    = PS_SIGNED;
                end else if (is_digit) begin
                    push_int_digit(d);
                    pp_phase = PS_INT;
                end else begin
                    pp_phase = PS_BAD;
                end
            end
            PS_SIGNED: begin
                if (is_digit) begin
                    push_int_digit(d);
                    pp_phase = PS_INT;
                end else begin
                    pp_phase = PS_BAD;
                end
            end
            PS_INT: begin
                if (is_digit) push_int_digit(d);
                else if (c == dtfp_pkg::CH_POINT) pp_phase = PS_FRAC;
                else pp_phase = PS_BAD;
            end
            PS_FRAC: begin
                // weight drops by ten per digit; once zero, digits add nothing
                if (is_digit) begin
                    pp_frac   = pp_frac + 32'(d) * pp_weight;
                    pp_weight = pp_weight / 32'd10;
                end else begin
                    pp_phase = PS_BAD;
                end
            end
            default: pp_phase = PS_BAD;
        endcase
        if (last) begin
            // not a number wins over overflow; NaN is never negated
            if (pp_phase != PS_INT && pp_phase != PS_FRAC) begin
                mag        = 64'd0;
                res.status = dtfp_pkg::ST_NAN;
            end else if (pp_ovf) begin
                mag        = (64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1;
                res.status = dtfp_pkg::ST_OVF;
            end else begin
                mag        = (64'(pp_int) << FRAC_BITS)
                           | 64'(pp_frac >> (32 - FRAC_BITS));
                res.status = dtfp_pkg::ST_OK;
            end
            if (pp_negative && res.status != dtfp_pkg::ST_NAN) mag = ~mag + 64'd1;
            res.value = mag;
            expected_results.push_back(res);
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_in_ready);
        parse_char(c, last);
        chars_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] txt[$]);
        foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        send_bytes(txt);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls per result, in-order scoreboard
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: value %h status %0d", o_value, o_status);
                    errors++;
                end else begin
                    if (o_value !== expected_results[0].value) begin
                        $error("value: expected %h, got %h",
                               expected_results[0].value, o_value);
                        errors++;
                    end
                    if (o_status !== expected_results[0].status) begin
                        $error("status: expected %0d, got %0d",
                               expected_results[0].status, o_status);
                        errors++;
                    end
                    void'(expected_results.pop_front());
                end
                ready_hold = draw_wait();
                i_out_ready <= (ready_hold == 0);
            end else if (!i_out_ready) begin
                if (ready_hold > 0) ready_hold--;
                if (ready_hold == 0) i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // zero, negative zero, explicit plus, trailing point, simple fraction
    task automatic test_well_formed();
        send_text("0");
        send_text("-0");
        send_text("+9.");
        send_text("-1.5");
    endtask

    // sign only, point first, second point, second sign, NUL, high byte
    task automatic test_malformed();
        send_text("-");
        send_text(".5");
        send_text("1..");
        send_text("+-");
        send_char(8'h34, 1'b0);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    // largest integer part, and one past it with a minus sign
    task automatic test_integer_bound();
        send_text("2147483647");
        send_text("-2147483648");
    endtask

    // mostly well-formed numbers with random content, mixed with broken ones and noise
    task automatic test_random_text();
        logic [7:0] txt[$];
        int         kind;
        int         n_int;
        int         style;
        int         spot;
        while (chars_sent < CHAR_GOAL) begin
            if ($urandom_range(0, 31) == 0) steady = ($urandom_range(0, 2) == 0);
            txt.delete();
            kind = $urandom_range(0, 99);
            if (kind >= 92) begin
                repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 3))
                    0:       txt.push_back(dtfp_pkg::CH_MINUS);
                    1:       txt.push_back(dtfp_pkg::CH_PLUS);
                    default: ;
                endcase
                // a few long integer parts reach saturation
                n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12)
                                                    : $urandom_range(1, 9);
                style = $urandom_range(0, 7);
                repeat (n_int) txt.push_back(pick_digit(style));
                if ($urandom_range(0, 3) != 0) begin
                    txt.push_back(dtfp_pkg::CH_POINT);
                    repeat ($urandom_range(0, 12)) txt.push_back(pick_digit(style));
                end
                // corrupt one character
                if (kind >= 80) begin
                    spot = $urandom_range(0, txt.size() - 1);
                    txt[spot] = 8'($urandom_range(0, 255));
                end
            end
            send_bytes(txt);
        end
        steady = 1'b0;
    endtask

    initial begin
        clear_parse();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_well_formed();
        test_malformed();
        test_integer_bound();
        test_random_text();

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
